/* rtl/chp_pkg.sv */
// Package for the compass heading block: widths, CORDIC constants, arctangent
// table and the stage payload type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

    // Number of CORDIC micro-rotations, one pipeline stage each
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_TABLE_LEN    = 24;

    // Field sample width
    localparam int FIELD_W = 16;
    // Vector components: 16-bit input scaled by 2^14, negated, grown by the CORDIC gain
    localparam int VEC_SHIFT = 14;
    localparam int VEC_W     = 33;
    // Angle accumulator in 2^-16 centidegree units
    localparam int ACC_W          = 33;
    localparam int ANGLE_FRAC_BITS = 16;
    // Rounded angle in centidegrees, and the wider sum used for the wrap
    localparam int ANGLE_W = 17;
    localparam int SUM_W   = 19;

    localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = ACC_W'(64'sd1179648000);
    localparam logic signed [ACC_W-1:0] ROUND_HALF    = ACC_W'(64'sd32768);
    localparam logic signed [SUM_W-1:0] FULL_TURN_CD  = SUM_W'(36000);
    localparam logic signed [15:0]      DECL_RESET    = 16'sd1400;

    // atan(2^-i) in degrees times 6553600, rounded
    localparam logic signed [31:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
        32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
        32'sd358,       32'sd179,       32'sd90,       32'sd45
    };

    // Payload carried between CORDIC stages
    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } t_vec;

endpackage

`default_nettype wire

/* rtl/chp_ifs.sv */
// Stream interfaces of the compass heading block: field samples in, headings
// out, and the declination write channel. Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface chp_field_if;
    import chp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_z;
    modport source (output valid, output field_x, output field_z, input ready);
    modport sink   (input valid, input field_x, input field_z, output ready);
endinterface

interface chp_head_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading_centideg;
    modport source (output valid, output heading_centideg, input ready);
    modport sink   (input valid, input heading_centideg, output ready);
endinterface

interface chp_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] declination_centideg;
    modport source (output valid, output declination_centideg, input ready);
    modport sink   (input valid, input declination_centideg, output ready);
endinterface

`default_nettype wire

/* rtl/chp_prerot.sv */
// Input stage: scales the field vector, folds the left half plane onto the
// right one and seeds the angle accumulator. Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_prerot
    import chp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic signed [FIELD_W-1:0] i_field_x,
    input  wire logic signed [FIELD_W-1:0] i_field_z,
    output      logic                      o_ready,
    output      logic                      o_valid,
    output      t_vec                      o_data,
    input  wire logic                      i_take
);

    logic r_valid;
    t_vec r_data;
    t_vec n_data;
    logic signed [VEC_W-1:0] w_sx;
    logic signed [VEC_W-1:0] w_sz;

    // Scale by 2^14 with sign extension
    assign w_sx = {{(VEC_W-FIELD_W-VEC_SHIFT){i_field_x[FIELD_W-1]}},
                   i_field_x, {VEC_SHIFT{1'b0}}};
    assign w_sz = {{(VEC_W-FIELD_W-VEC_SHIFT){i_field_z[FIELD_W-1]}},
                   i_field_z, {VEC_SHIFT{1'b0}}};

    // Negate the vector in the left half plane, start at +/-180 degrees.
    // The half-centidegree rounding offset rides in the seed, so the output
    // stage only truncates.
    always_comb begin
        n_data.zero = (i_field_x == '0) && (i_field_z == '0);
        if (i_field_x[FIELD_W-1]) begin
            n_data.vx  = -w_sx;
            n_data.vy  = -w_sz;
            n_data.acc = i_field_z[FIELD_W-1] ? (ROUND_HALF - HALF_TURN_ACC)
                                              : (ROUND_HALF + HALF_TURN_ACC);
        end else begin
            n_data.vx  = w_sx;
            n_data.vy  = w_sz;
            n_data.acc = ROUND_HALF;
        end
    end

    assign o_ready = !r_valid || i_take;

    // Hold while downstream stalls, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* rtl/chp_cordic.sv */
// Vectoring CORDIC pipeline: one micro-rotation per register stage, with a
// valid bit and a local stall per stage. Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_cordic
    import chp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_vec i_data,
    output      logic o_ready,
    output      logic o_valid,
    output      t_vec o_data,
    input  wire logic i_take
);

    logic r_valid [CORDIC_ITERATIONS];
    t_vec r_data  [CORDIC_ITERATIONS];
    logic w_adv   [CORDIC_ITERATIONS];

    for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_stage
        logic w_in_valid;
        t_vec w_in;
        t_vec n_data;
        logic signed [VEC_W-1:0] w_dx;
        logic signed [VEC_W-1:0] w_dy;
        logic signed [ACC_W-1:0] w_ang;

        // Pick up the previous stage
        if (k == 0) begin : g_first
            assign w_in_valid = i_valid;
            assign w_in       = i_data;
        end else begin : g_next
            assign w_in_valid = r_valid[k-1];
            assign w_in       = r_data[k-1];
        end

        // Stage may load when empty or when its contents move on
        if (k == CORDIC_ITERATIONS - 1) begin : g_last
            assign w_adv[k] = !r_valid[k] || i_take;
        end else begin : g_mid
            assign w_adv[k] = !r_valid[k] || w_adv[k+1];
        end

        assign w_dx  = w_in.vy >>> k;
        assign w_dy  = w_in.vx >>> k;
        assign w_ang = ACC_W'(ATAN_TABLE[k]);

        // Rotate toward the x axis
        always_comb begin
            n_data.zero = w_in.zero;
            if (w_in.vy > 0) begin
                n_data.vx  = w_in.vx + w_dx;
                n_data.vy  = w_in.vy - w_dy;
                n_data.acc = w_in.acc + w_ang;
            end else begin
                n_data.vx  = w_in.vx - w_dx;
                n_data.vy  = w_in.vy + w_dy;
                n_data.acc = w_in.acc - w_ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_valid[k] <= w_in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k] && w_in_valid) begin
                r_data[k] <= n_data;
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_valid[CORDIC_ITERATIONS-1];
    assign o_data  = r_data[CORDIC_ITERATIONS-1];

endmodule

`default_nettype wire

/* rtl/chp_post.sv */
// Output stage: rounds the angle to centidegrees, adds the declination and
// wraps once by a full turn toward 0..36000. Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_post
    import chp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_vec               i_data,
    input  wire logic signed [15:0] i_decl,
    output      logic               o_ready,
    output      logic               o_valid,
    output      logic [15:0]        o_heading,
    input  wire logic               i_take
);

    logic                      r_valid;
    logic [15:0]               r_heading;
    logic signed [ACC_W-1:0]   w_shift;
    logic signed [ANGLE_W-1:0] w_angle;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_wrap_lo;
    logic signed [SUM_W-1:0]   w_wrap_hi;
    logic signed [SUM_W-1:0]   n_heading;

    // Round to nearest, ties up: the half step was added to the seed
    assign w_shift = i_data.acc >>> ANGLE_FRAC_BITS;
    assign w_angle = i_data.zero ? '0 : w_shift[ANGLE_W-1:0];
    assign w_sum   = SUM_W'(w_angle) + SUM_W'(i_decl);

    // Wrap once: both corrections in parallel, then select
    assign w_wrap_lo = w_sum + FULL_TURN_CD;
    assign w_wrap_hi = w_sum - FULL_TURN_CD;

    always_comb begin
        if (w_sum < 0) begin
            n_heading = w_wrap_lo;
        end else if (w_sum > FULL_TURN_CD) begin
            n_heading = w_wrap_hi;
        end else begin
            n_heading = w_sum;
        end
    end

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_heading <= n_heading[15:0];
        end
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

endmodule

`default_nettype wire

/* rtl/compass_heading_from_field_unit.sv */
// Compass heading from two field components: atan2(z, x) by CORDIC plus declination.
// Pipeline of 1 input stage, 16 CORDIC stages and 1 rounding/wrap stage.
// Throughput one beat per cycle while the output is taken; every stage holds its
// beat under back-pressure and loads whenever it is empty or moving on.
// Synchronous active-low reset empties all stages and sets the declination to 14.00 deg.
// Depends on chp_pkg, chp_ifs, chp_prerot, chp_cordic and chp_post.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_from_field_unit
    import chp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    chp_field_if.sink   i_field,
    chp_cfg_if.sink     i_cfg,
    chp_head_if.source  o_head
);

    logic signed [15:0] r_decl;
    logic               w_pre_valid;
    t_vec               w_pre_data;
    logic               w_cor_ready;
    logic               w_cor_valid;
    t_vec               w_cor_data;
    logic               w_post_ready;

    // Declination register: accept a write beat every cycle
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
        end else if (i_cfg.valid) begin
            r_decl <= i_cfg.declination_centideg;
        end
    end

    chp_prerot u_prerot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_field.valid),
        .i_field_x (i_field.field_x),
        .i_field_z (i_field.field_z),
        .o_ready   (i_field.ready),
        .o_valid   (w_pre_valid),
        .o_data    (w_pre_data),
        .i_take    (w_cor_ready)
    );

    chp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pre_valid),
        .i_data  (w_pre_data),
        .o_ready (w_cor_ready),
        .o_valid (w_cor_valid),
        .o_data  (w_cor_data),
        .i_take  (w_post_ready)
    );

    chp_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_cor_valid),
        .i_data    (w_cor_data),
        .i_decl    (r_decl),
        .o_ready   (w_post_ready),
        .o_valid   (o_head.valid),
        .o_heading (o_head.heading_centideg),
        .i_take    (o_head.ready)
    );

endmodule

`default_nettype wire
